// File: rtl/pid_steering_controller_core_defines.svh
// Assertion macros shared by the PID steering controller RTL.
`ifndef PID_STEERING_CONTROLLER_CORE_DEFINES_SVH
`define PID_STEERING_CONTROLLER_CORE_DEFINES_SVH

// Checks a property on every clock edge outside reset.
`define PSCC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that a condition holds on the cycle after a trigger.
`define PSCC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/pscc_pkg.sv
// Shared types and constants of the PID steering controller.
package pscc_pkg;

	localparam int GAIN_WIDTH      = 16;
	localparam int COUNT_WIDTH     = 32;
	localparam int DRIVE_WIDTH     = 32;
	localparam int METRIC_WIDTH    = 48;
	localparam int CFG_INDEX_WIDTH = 2;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_KP = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_KI = 2'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_KD = 2'd2;

	typedef struct packed {
		logic clr;
		logic mul_en;
		logic acc_en;
	} mac_ctl_t;

endpackage

// File: rtl/pscc_ifs.sv
// Handshake channel interfaces of the PID steering controller.
interface pscc_sample_if #(
	parameter int SAMPLE_WIDTH = 16
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] track_error;

	modport source (output valid, output track_error, input ready);
	modport sink (input valid, input track_error, output ready);
endinterface

interface pscc_result_if;
	import pscc_pkg::*;

	logic                          valid;
	logic                          ready;
	logic signed [DRIVE_WIDTH-1:0] drive_value;
	logic [METRIC_WIDTH-1:0]       error_metric;

	modport source (output valid, output drive_value, output error_metric, input ready);
	modport sink (input valid, input drive_value, input error_metric, output ready);
endinterface

interface pscc_cfg_if;
	import pscc_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [CFG_INDEX_WIDTH-1:0] index;
	logic [GAIN_WIDTH-1:0]      data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/pscc_mac.sv
// Shared multiplier with a registered product and a subtracting accumulator.
module pscc_mac #(
	parameter int A_W   = 17,
	parameter int B_W   = 33,
	parameter int ACC_W = 52
) (
	input  logic                      clk,
	input  pscc_pkg::mac_ctl_t        ctl,
	input  logic signed [A_W-1:0]     op_a,
	input  logic signed [B_W-1:0]     op_b,
	output logic signed [A_W+B_W-1:0] prod,
	output logic signed [ACC_W-1:0]   acc
);
	import pscc_pkg::*;

	localparam int PROD_W = A_W + B_W;

	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_q <= op_a * op_b;
		end
		if (ctl.clr) begin
			acc_q <= '0;
		end else if (ctl.acc_en) begin
			acc_q <= acc_q - ACC_W'(prod_q);
		end
	end

	assign prod = prod_q;
	assign acc  = acc_q;
endmodule

// File: rtl/pscc_div.sv
// Restoring divider that produces one quotient bit per cycle.
module pscc_div #(
	parameter int DVD_W = 31,
	parameter int DVS_W = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             busy,
	output logic [DVD_W-1:0] quotient
);
	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign fits  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(DVD_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[DVD_W-2:0], fits};
			if (fits) begin
				rem_q <= DVS_W'(trial - {1'b0, dvs_q});
			end else begin
				rem_q <= trial[DVS_W-1:0];
			end
		end
	end

	assign busy     = (cnt_q != '0);
	assign quotient = dvd_q;
endmodule

// File: rtl/pid_steering_controller_core.sv
// Top level of the PID steering controller: sequencer, state and result register.
//
//   channel  dir  handshake      payload
//   sample   in   valid/ready    track_error
//   result   out  valid/ready    drive_value, error_metric
//   cfg      in   valid/ready    index, data (gain registers 0..2)
//
// Each result waits on the divider, which forms one bit of e*e/count per cycle.
// The four products go one per cycle through the single shared multiplier.
// A new request is taken as soon as the result is registered, even while it waits.
// A stalled result holds the sequencer in its last step.
// Reset clears the gains, the sequencer, previous error, integral, count and metric.
`include "pid_steering_controller_core_defines.svh"

module pid_steering_controller_core #(
	parameter int SAMPLE_WIDTH   = 16,
	parameter int ACCUM_WIDTH    = 32,
	parameter int GAIN_FRAC_BITS = 12
) (
	input logic          clk,
	input logic          arst_n,
	pscc_sample_if.sink  sample,
	pscc_result_if.source result,
	pscc_cfg_if.sink     cfg
);
	import pscc_pkg::*;

	localparam int DIFF_W = SAMPLE_WIDTH + 1;
	localparam int OPA_W  = (GAIN_WIDTH > SAMPLE_WIDTH) ? GAIN_WIDTH : SAMPLE_WIDTH;
	localparam int OPB_W  = (DIFF_W > ACCUM_WIDTH) ? DIFF_W : ACCUM_WIDTH;
	localparam int PROD_W = OPA_W + OPB_W;
	localparam int ACC_W  = PROD_W + 2;
	localparam int SH_W   = ACC_W - GAIN_FRAC_BITS;
	localparam int EXT_W  = (SH_W > DRIVE_WIDTH) ? SH_W : DRIVE_WIDTH;
	localparam int INT_W  = ((ACCUM_WIDTH > SAMPLE_WIDTH) ? ACCUM_WIDTH : SAMPLE_WIDTH) + 1;
	localparam int SQ_W   = 2 * SAMPLE_WIDTH - 1;
	localparam int MS_W   = ((SQ_W > METRIC_WIDTH) ? SQ_W : METRIC_WIDTH) + 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	localparam logic [2:0] STEP_SQ  = 3'd0;
	localparam logic [2:0] STEP_KP  = 3'd1;
	localparam logic [2:0] STEP_KD  = 3'd2;
	localparam logic [2:0] STEP_KI  = 3'd3;
	localparam logic [2:0] STEP_END = 3'd4;

	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (GAIN_FRAC_BITS - 1);

	logic [1:0] state_q;
	logic [2:0] step_q;

	logic signed [GAIN_WIDTH-1:0]   kp_q;
	logic signed [GAIN_WIDTH-1:0]   ki_q;
	logic signed [GAIN_WIDTH-1:0]   kd_q;
	logic signed [SAMPLE_WIDTH-1:0] e_q;
	logic signed [SAMPLE_WIDTH-1:0] prev_q;
	logic signed [DIFF_W-1:0]       diff_q;
	logic signed [ACCUM_WIDTH-1:0]  integral_q;
	logic [COUNT_WIDTH-1:0]         count_q;
	logic [METRIC_WIDTH-1:0]        metric_q;

	logic                           res_valid_q;
	logic signed [DRIVE_WIDTH-1:0]  drive_q;
	logic [METRIC_WIDTH-1:0]        metric_out_q;

	logic                     accept;
	logic                     load_out;
	logic signed [INT_W-1:0]  int_sum;
	logic signed [ACCUM_WIDTH-1:0] int_next;
	mac_ctl_t                 mac_ctl;
	logic signed [OPA_W-1:0]  op_a;
	logic signed [OPB_W-1:0]  op_b;
	logic signed [PROD_W-1:0] prod;
	logic signed [ACC_W-1:0]  acc;
	logic                     div_start;
	logic                     div_busy;
	logic [SQ_W-1:0]          quotient;
	logic signed [ACC_W-1:0]  rounded;
	logic signed [SH_W-1:0]   shifted;
	logic signed [EXT_W-1:0]  shifted_ext;
	logic signed [DRIVE_WIDTH-1:0] drive_next;
	logic [MS_W-1:0]          metric_sum;
	logic [METRIC_WIDTH-1:0]  metric_next;

	assign accept       = sample.valid && sample.ready;
	assign sample.ready = (state_q == ST_IDLE);
	assign cfg.ready    = 1'b1;
	assign load_out     = (state_q == ST_FIN) && (!res_valid_q || result.ready);

	always_comb begin
		int_sum = INT_W'(integral_q) + INT_W'(sample.track_error);
		if (int_sum[INT_W-1:ACCUM_WIDTH-1] == {(INT_W-ACCUM_WIDTH+1){int_sum[INT_W-1]}}) begin
			int_next = int_sum[ACCUM_WIDTH-1:0];
		end else if (int_sum[INT_W-1]) begin
			int_next = {1'b1, {(ACCUM_WIDTH-1){1'b0}}};
		end else begin
			int_next = {1'b0, {(ACCUM_WIDTH-1){1'b1}}};
		end
	end

	always_comb begin
		case (step_q)
			STEP_SQ: begin
				op_a = OPA_W'(e_q);
				op_b = OPB_W'(e_q);
			end
			STEP_KP: begin
				op_a = OPA_W'(kp_q);
				op_b = OPB_W'(e_q);
			end
			STEP_KD: begin
				op_a = OPA_W'(kd_q);
				op_b = OPB_W'(diff_q);
			end
			STEP_KI: begin
				op_a = OPA_W'(ki_q);
				op_b = OPB_W'(integral_q);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	always_comb begin
		mac_ctl.clr    = accept;
		mac_ctl.mul_en = (state_q == ST_MUL) && (step_q <= STEP_KI);
		mac_ctl.acc_en = (state_q == ST_MUL) && (step_q >= STEP_KD);
	end

	assign div_start = (state_q == ST_MUL) && (step_q == STEP_KP);

	pscc_mac #(
		.A_W  (OPA_W),
		.B_W  (OPB_W),
		.ACC_W(ACC_W)
	) u_mac (
		.clk (clk),
		.ctl (mac_ctl),
		.op_a(op_a),
		.op_b(op_b),
		.prod(prod),
		.acc (acc)
	);

	pscc_div #(
		.DVD_W(SQ_W),
		.DVS_W(COUNT_WIDTH)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(prod[SQ_W-1:0]),
		.divisor (count_q),
		.busy    (div_busy),
		.quotient(quotient)
	);

	always_comb begin
		rounded     = acc + ROUND_HALF;
		shifted     = rounded[ACC_W-1:GAIN_FRAC_BITS];
		shifted_ext = EXT_W'(shifted);
		if (shifted_ext[EXT_W-1:DRIVE_WIDTH-1] ==
				{(EXT_W-DRIVE_WIDTH+1){shifted_ext[EXT_W-1]}}) begin
			drive_next = shifted_ext[DRIVE_WIDTH-1:0];
		end else if (shifted_ext[EXT_W-1]) begin
			drive_next = {1'b1, {(DRIVE_WIDTH-1){1'b0}}};
		end else begin
			drive_next = {1'b0, {(DRIVE_WIDTH-1){1'b1}}};
		end
		metric_sum = MS_W'(metric_q) + MS_W'(quotient);
		if (metric_sum[MS_W-1:METRIC_WIDTH] != '0) begin
			metric_next = '1;
		end else begin
			metric_next = metric_sum[METRIC_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q <= '0;
			ki_q <= '0;
			kd_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_KP: kp_q <= cfg.data;
				REG_KI: ki_q <= cfg.data;
				REG_KD: kd_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= STEP_SQ;
			prev_q      <= '0;
			integral_q  <= '0;
			count_q     <= '0;
			metric_q    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						prev_q     <= sample.track_error;
						integral_q <= int_next;
						if (count_q != '1) begin
							count_q <= count_q + 1'b1;
						end
						step_q  <= STEP_SQ;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_END) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (!div_busy) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (load_out) begin
						metric_q <= metric_next;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			e_q    <= sample.track_error;
			diff_q <= DIFF_W'(sample.track_error) - DIFF_W'(prev_q);
		end
		if (load_out) begin
			drive_q      <= drive_next;
			metric_out_q <= metric_next;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.drive_value  = drive_q;
	assign result.error_metric = metric_out_q;

	`PSCC_ASSERT_NEXT(a_one_request_at_a_time, accept, !sample.ready, "Request accepted while busy.")
	`PSCC_ASSERT(a_div_in_phase, div_busy |-> (state_q == ST_MUL || state_q == ST_DIV), "Divider runs outside its phase.")
	`PSCC_ASSERT_NEXT(a_count_nonzero, accept, count_q != '0, "Sample count is zero after a request.")
endmodule
